[hw/rtl/tga_pkg.sv]
package tga_pkg;

    // decoder phase
    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_INFO   = 3'd1,
        PH_PACKET = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_DRAIN  = 3'd4
    } t_phase;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE = 3'd1;
    localparam logic [2:0] ST_BAD_INFO = 3'd2;
    localparam logic [2:0] ST_OVERRUN  = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    // header layout
    localparam logic [3:0] TYPE_LAST     = 4'd11;
    localparam logic [3:0] TYPE_CODE_POS = 4'd2;
    localparam logic [7:0] TYPE_RAW      = 8'd2;
    localparam logic [7:0] TYPE_RLE      = 8'd10;
    localparam logic [3:0] INFO_LAST     = 4'd5;
    localparam logic [3:0] INFO_W_LO     = 4'd0;
    localparam logic [3:0] INFO_W_HI     = 4'd1;
    localparam logic [3:0] INFO_H_LO     = 4'd2;
    localparam logic [3:0] INFO_H_HI     = 4'd3;
    localparam logic [3:0] INFO_BPP      = 4'd4;
    localparam logic [7:0] BPP_RGB       = 8'd24;
    localparam logic [7:0] BPP_RGBA      = 8'd32;

    // RLE packet header
    localparam logic [7:0] RAW_LIMIT = 8'd128;
    localparam logic [7:0] RUN_BIAS  = 8'd127;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        has_alpha;
        logic [7:0]  repeat_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  status;
        logic        image_end;
    } t_result;

endpackage

[hw/rtl/tga_dec_core.sv]
module tga_dec_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_res_valid,
    output tga_pkg::t_result  o_res
);

    tga_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    logic [1:0]  r_mis, n_mis;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_four, n_four;
    logic        r_rle, n_rle;
    logic [31:0] r_pix_left, n_pix_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run, n_pkt_run;
    logic [23:0] r_pix, n_pix;
    logic [1:0]  r_byte_idx, n_byte_idx;

    logic        clr;
    logic        pix_v;
    logic        endf;
    logic [2:0]  status;
    logic [7:0]  rep;
    logic [7:0]  red, green, blue, alpha;

    logic [1:0]  mis_now;
    logic [7:0]  bpp;
    logic [31:0] area;
    logic [31:0] pkt_wide;
    logic [31:0] pix_dec;
    logic [7:0]  pkt_dec;
    logic        pix_done;

    assign mis_now[0] = i_data_byte !=
                        ((r_hdr_idx == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_RAW : 8'd0);
    assign mis_now[1] = i_data_byte !=
                        ((r_hdr_idx == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_RLE : 8'd0);
    assign bpp      = r_pix[7:0];
    assign area     = {16'd0, r_width} * {16'd0, r_height};
    assign pkt_wide = {24'd0, r_pkt_left};
    assign pix_dec  = (r_pix_left != 32'd0) ? r_pix_left - 32'd1 : 32'd0;
    assign pkt_dec  = (r_pkt_left != 8'd0) ? r_pkt_left - 8'd1 : 8'd0;
    assign pix_done = (r_byte_idx == 2'd3) || (!r_four && r_byte_idx == 2'd2);

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_mis      = r_mis;
        n_width    = r_width;
        n_height   = r_height;
        n_four     = r_four;
        n_rle      = r_rle;
        n_pix_left = r_pix_left;
        n_pkt_left = r_pkt_left;
        n_pkt_run  = r_pkt_run;
        n_pix      = r_pix;
        n_byte_idx = r_byte_idx;
        pix_v      = 1'b0;
        endf       = 1'b0;
        status     = tga_pkg::ST_OK;
        rep        = 8'd0;
        clr        = 1'b0;

        case (r_phase)
            tga_pkg::PH_TYPE: begin
                n_mis = r_mis | mis_now;
                if (r_hdr_idx == tga_pkg::TYPE_LAST) begin
                    if (n_mis == 2'b11) begin
                        status = tga_pkg::ST_BAD_TYPE;
                        endf   = 1'b1;
                    end else begin
                        n_rle     = n_mis[0];
                        n_phase   = tga_pkg::PH_INFO;
                        n_hdr_idx = 4'd0;
                    end
                end else begin
                    n_hdr_idx = r_hdr_idx + 4'd1;
                end
            end
            tga_pkg::PH_INFO: begin
                case (r_hdr_idx)
                    tga_pkg::INFO_W_LO: n_width[7:0]   = i_data_byte;
                    tga_pkg::INFO_W_HI: n_width[15:8]  = i_data_byte;
                    tga_pkg::INFO_H_LO: n_height[7:0]  = i_data_byte;
                    tga_pkg::INFO_H_HI: n_height[15:8] = i_data_byte;
                    tga_pkg::INFO_BPP:  n_pix          = {16'd0, i_data_byte};
                    default: ;
                endcase
                if (r_hdr_idx == tga_pkg::INFO_LAST) begin
                    if (r_width == 16'd0 || r_height == 16'd0 ||
                        (bpp != tga_pkg::BPP_RGB && bpp != tga_pkg::BPP_RGBA)) begin
                        status = tga_pkg::ST_BAD_INFO;
                        endf   = 1'b1;
                    end else begin
                        n_four     = (bpp == tga_pkg::BPP_RGBA);
                        n_pix_left = area;
                        n_pkt_left = 8'd0;
                        n_pkt_run  = 1'b0;
                        n_byte_idx = 2'd0;
                        n_phase    = r_rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
                    end
                    n_pix     = 24'd0;
                    n_hdr_idx = 4'd0;
                end else begin
                    n_hdr_idx = r_hdr_idx + 4'd1;
                end
            end
            tga_pkg::PH_PACKET: begin
                if (i_data_byte < tga_pkg::RAW_LIMIT) begin
                    n_pkt_left = i_data_byte + 8'd1;
                    n_pkt_run  = 1'b0;
                end else begin
                    n_pkt_left = i_data_byte - tga_pkg::RUN_BIAS;
                    n_pkt_run  = 1'b1;
                end
                n_byte_idx = 2'd0;
                n_pix      = 24'd0;
                n_phase    = tga_pkg::PH_PIXEL;
            end
            tga_pkg::PH_PIXEL: begin
                if (pix_done) begin
                    pix_v      = 1'b1;
                    n_byte_idx = 2'd0;
                    n_pix      = 24'd0;
                    if (r_rle && r_pkt_run) begin
                        if (pkt_wide > r_pix_left) begin
                            rep        = r_pix_left[7:0];
                            status     = tga_pkg::ST_OVERRUN;
                            n_pix_left = 32'd0;
                            endf       = 1'b1;
                        end else begin
                            rep        = r_pkt_left;
                            n_pix_left = r_pix_left - pkt_wide;
                            if (n_pix_left == 32'd0) begin
                                endf = 1'b1;
                            end else begin
                                n_phase = tga_pkg::PH_PACKET;
                            end
                        end
                        n_pkt_left = 8'd0;
                    end else if (r_rle) begin
                        rep        = 8'd1;
                        n_pix_left = pix_dec;
                        n_pkt_left = pkt_dec;
                        if (pix_dec == 32'd0) begin
                            endf = 1'b1;
                            if (pkt_dec != 8'd0) begin
                                status = tga_pkg::ST_OVERRUN;
                            end
                        end else if (pkt_dec == 8'd0) begin
                            n_phase = tga_pkg::PH_PACKET;
                        end
                    end else begin
                        rep        = 8'd1;
                        n_pix_left = pix_dec;
                        endf       = (pix_dec == 32'd0);
                    end
                end else begin
                    n_byte_idx = r_byte_idx + 2'd1;
                    case (r_byte_idx)
                        2'd0:    n_pix[7:0]   = i_data_byte;
                        2'd1:    n_pix[15:8]  = i_data_byte;
                        2'd2:    n_pix[23:16] = i_data_byte;
                        default: ;
                    endcase
                end
            end
            default: begin
                // drain to end of file
                clr     = i_last_byte;
                n_phase = tga_pkg::PH_DRAIN;
            end
        endcase

        if (r_phase != tga_pkg::PH_DRAIN && r_phase <= tga_pkg::PH_PIXEL) begin
            if (!endf && i_last_byte) begin
                status = tga_pkg::ST_TRUNC;
                endf   = 1'b1;
            end
            if (endf) begin
                clr     = i_last_byte;
                n_phase = tga_pkg::PH_DRAIN;
            end
        end
    end

    // result fields
    always_comb begin
        blue  = 8'd0;
        green = 8'd0;
        red   = 8'd0;
        alpha = 8'd0;
        if (pix_v) begin
            blue  = r_pix[7:0];
            green = r_pix[15:8];
            red   = (r_byte_idx == 2'd2) ? i_data_byte : r_pix[23:16];
            alpha = r_four ? i_data_byte : 8'd0;
        end
        o_res_valid         = i_accept && (pix_v || endf);
        o_res.pixel_valid   = pix_v;
        o_res.red           = red;
        o_res.green         = green;
        o_res.blue          = blue;
        o_res.alpha         = alpha;
        o_res.has_alpha     = n_four;
        o_res.repeat_count  = rep;
        o_res.image_width   = n_width;
        o_res.image_height  = n_height;
        o_res.status        = status;
        o_res.image_end     = endf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && clr)) begin
            r_phase    <= tga_pkg::PH_TYPE;
            r_hdr_idx  <= 4'd0;
            r_mis      <= 2'b00;
            r_width    <= 16'd0;
            r_height   <= 16'd0;
            r_four     <= 1'b0;
            r_rle      <= 1'b0;
            r_pix_left <= 32'd0;
            r_pkt_left <= 8'd0;
            r_pkt_run  <= 1'b0;
            r_pix      <= 24'd0;
            r_byte_idx <= 2'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_mis      <= n_mis;
            r_width    <= n_width;
            r_height   <= n_height;
            r_four     <= n_four;
            r_rle      <= n_rle;
            r_pix_left <= n_pix_left;
            r_pkt_left <= n_pkt_left;
            r_pkt_run  <= n_pkt_run;
            r_pix      <= n_pix;
            r_byte_idx <= n_byte_idx;
        end
    end

    // pixel phase always has pixels outstanding
    a_pix_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tga_pkg::PH_PIXEL) |-> (r_pix_left != 32'd0))
        else $error("pixel phase with no pixels left");

    // draining bytes never produce a result
    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == tga_pkg::PH_DRAIN) |-> !o_res_valid)
        else $error("result during drain");

    // any error status ends the image
    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != tga_pkg::ST_OK) |-> o_res.image_end)
        else $error("error status without image end");

endmodule

[hw/rtl/tga_out_buf.sv]
module tga_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tga_pkg::t_result  i_item,
    output logic              o_full,
    output logic              o_valid,
    output tga_pkg::t_result  o_item,
    input  logic              i_stall
);

    logic             r_out_v;
    logic             r_skid_v;
    tga_pkg::t_result r_out;
    tga_pkg::t_result r_skid;
    logic             out_free;

    assign out_free = !r_out_v || !i_stall;
    assign o_full   = r_skid_v;
    assign o_valid  = r_out_v;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : i_item;
        end else if (i_push) begin
            r_skid <= i_item;
        end
    end

    // skid only fills behind a held output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid full with output empty");

    // nothing pushed while the skid is occupied
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_v)
        else $error("push into full buffer");

    // a stalled item stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> (r_out_v && $stable(r_out)))
        else $error("output changed while stalled");

endmodule

[hw/rtl/tga_image_decoder.sv]
// TGA image decoder. Feed the file one byte per item on i_data_byte, with
// i_last_byte marking the final byte. The 12-byte type header must be the
// uncompressed (type 2) or RLE (type 10) true-colour pattern; six info bytes
// then give width, height, bits per pixel (24 or 32) and an ignored
// descriptor. Each pixel comes out as one result with red and blue swapped
// back from the stored BGR(A) order; an RLE run is reported once with its
// repeat count, raw pixels with a count of one. The result that finishes the
// image or reports an error has o_image_end set; status codes are ok, bad type
// header, bad info, too many pixels (the packet overran the image and was
// clipped) and truncated (file ended early; any pixel finished by that byte
// rides on the same result). After an end, bytes are swallowed up to and
// including the one flagged last, and the next byte starts a fresh file.
// Rate: one byte per clock, sustained, with no gaps between files; each byte
// passes through a single registered decode step, and results are held in a
// two-entry output buffer, so o_in_stall only rises when both entries are full
// under a stalled output.
module tga_image_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_pixel_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_has_alpha,
    output logic [7:0]  o_repeat_count,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [2:0]  o_status,
    output logic        o_image_end
);

    logic             accept;
    logic             res_valid;
    tga_pkg::t_result res;
    tga_pkg::t_result out_item;
    logic             buf_full;

    // byte taken whenever the skid entry is free
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    // header parse, packet and pixel assembly
    tga_dec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register plus skid entry
    tga_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_item  (out_item),
        .i_stall (i_out_stall)
    );

    assign o_pixel_valid  = out_item.pixel_valid;
    assign o_red          = out_item.red;
    assign o_green        = out_item.green;
    assign o_blue         = out_item.blue;
    assign o_alpha        = out_item.alpha;
    assign o_has_alpha    = out_item.has_alpha;
    assign o_repeat_count = out_item.repeat_count;
    assign o_image_width  = out_item.image_width;
    assign o_image_height = out_item.image_height;
    assign o_status       = out_item.status;
    assign o_image_end    = out_item.image_end;

endmodule

[sim/tga_image_decoder_checker.sv]
module tga_image_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_pixel_valid,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_alpha,
    input  logic        i_has_alpha,
    input  logic [7:0]  i_repeat_count,
    input  logic [15:0] i_image_width,
    input  logic [15:0] i_image_height,
    input  logic [2:0]  i_status,
    input  logic        i_image_end,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state mirror
    tga_pkg::t_phase dec_phase;
    logic [3:0]  hdr_idx;
    logic [1:0]  type_miss;
    logic [15:0] width_r;
    logic [15:0] height_r;
    logic        rgba;
    logic        rle;
    logic [31:0] pix_left;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [31:0] pix_acc;
    logic [1:0]  byte_pos;

    tga_pkg::t_result decoded_q[$];
    int          mismatches = 0;

    assign o_errors = mismatches;

    function automatic void clear_state();
        dec_phase = tga_pkg::PH_TYPE;
        hdr_idx   = '0;
        type_miss = '0;
        width_r   = '0;
        height_r  = '0;
        rgba      = 1'b0;
        rle       = 1'b0;
        pix_left  = '0;
        pkt_left  = '0;
        pkt_run   = 1'b0;
        pix_acc   = '0;
        byte_pos  = '0;
    endfunction

    // one file byte in; returns 1 when it yields a result
    function automatic bit decode_byte(input logic [7:0] b, input logic is_last,
                                       output tga_pkg::t_result res);
        logic [7:0] want_raw;
        logic [7:0] want_rle;
        logic       fin;
        res = '0;
        fin = 1'b0;
        if (dec_phase == tga_pkg::PH_DRAIN) begin
            if (is_last) clear_state();
            return 1'b0;
        end
        case (dec_phase)
            tga_pkg::PH_TYPE: begin
                want_raw = (hdr_idx == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_RAW : 8'd0;
                want_rle = (hdr_idx == tga_pkg::TYPE_CODE_POS) ? tga_pkg::TYPE_RLE : 8'd0;
                if (b != want_raw) type_miss[0] = 1'b1;
                if (b != want_rle) type_miss[1] = 1'b1;
                if (hdr_idx == tga_pkg::TYPE_LAST) begin
                    if (&type_miss) begin
                        res.status = tga_pkg::ST_BAD_TYPE;
                        fin = 1'b1;
                    end else begin
                        rle       = type_miss[0];
                        dec_phase = tga_pkg::PH_INFO;
                        hdr_idx   = '0;
                    end
                end else begin
                    hdr_idx++;
                end
            end
            tga_pkg::PH_INFO: begin
                case (hdr_idx)
                    tga_pkg::INFO_W_LO: width_r[7:0]   = b;
                    tga_pkg::INFO_W_HI: width_r[15:8]  = b;
                    tga_pkg::INFO_H_LO: height_r[7:0]  = b;
                    tga_pkg::INFO_H_HI: height_r[15:8] = b;
                    tga_pkg::INFO_BPP:  pix_acc        = {24'd0, b};
                    default: ;
                endcase
                if (hdr_idx == tga_pkg::INFO_LAST) begin
                    if (width_r == '0 || height_r == '0 ||
                        (pix_acc[7:0] != tga_pkg::BPP_RGB &&
                         pix_acc[7:0] != tga_pkg::BPP_RGBA)) begin
                        res.status = tga_pkg::ST_BAD_INFO;
                        fin = 1'b1;
                    end else begin
                        rgba      = (pix_acc[7:0] == tga_pkg::BPP_RGBA);
                        pix_left  = 32'(width_r) * 32'(height_r);
                        pkt_left  = '0;
                        pkt_run   = 1'b0;
                        byte_pos  = '0;
                        dec_phase = rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
                    end
                    pix_acc = '0;
                    hdr_idx = '0;
                end else begin
                    hdr_idx++;
                end
            end
            tga_pkg::PH_PACKET: begin
                if (b < tga_pkg::RAW_LIMIT) begin
                    pkt_left = b + 8'd1;
                    pkt_run  = 1'b0;
                end else begin
                    pkt_left = b - tga_pkg::RUN_BIAS;
                    pkt_run  = 1'b1;
                end
                byte_pos  = '0;
                pix_acc   = '0;
                dec_phase = tga_pkg::PH_PIXEL;
            end
            default: begin
                pix_acc[8*byte_pos +: 8] = b;
                if (byte_pos == (rgba ? 2'd3 : 2'd2)) begin
                    // stored BGR(A), emitted RGB(A)
                    res.pixel_valid = 1'b1;
                    res.blue  = pix_acc[7:0];
                    res.green = pix_acc[15:8];
                    res.red   = pix_acc[23:16];
                    res.alpha = rgba ? pix_acc[31:24] : 8'd0;
                    byte_pos  = '0;
                    pix_acc   = '0;
                    if (rle && pkt_run) begin
                        if (32'(pkt_left) > pix_left) begin
                            // run clipped to what is left of the image
                            res.repeat_count = pix_left[7:0];
                            res.status = tga_pkg::ST_OVERRUN;
                            pix_left = '0;
                            fin = 1'b1;
                        end else begin
                            res.repeat_count = pkt_left;
                            pix_left -= 32'(pkt_left);
                            if (pix_left == '0) fin = 1'b1;
                            else dec_phase = tga_pkg::PH_PACKET;
                        end
                        pkt_left = '0;
                    end else if (rle) begin
                        res.repeat_count = 8'd1;
                        if (pix_left != '0) pix_left--;
                        if (pkt_left != '0) pkt_left--;
                        if (pix_left == '0) begin
                            fin = 1'b1;
                            if (pkt_left != '0) res.status = tga_pkg::ST_OVERRUN;
                        end else if (pkt_left == '0) begin
                            dec_phase = tga_pkg::PH_PACKET;
                        end
                    end else begin
                        res.repeat_count = 8'd1;
                        if (pix_left != '0) pix_left--;
                        if (pix_left == '0) fin = 1'b1;
                    end
                end else begin
                    byte_pos++;
                end
            end
        endcase
        if (!fin && is_last) begin
            res.status = tga_pkg::ST_TRUNC;
            fin = 1'b1;
        end
        if (!res.pixel_valid && !fin) return 1'b0;
        res.has_alpha    = rgba;
        res.image_width  = width_r;
        res.image_height = height_r;
        res.image_end    = fin;
        if (fin) begin
            if (is_last) clear_state();
            else dec_phase = tga_pkg::PH_DRAIN;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        tga_pkg::t_result got;
        tga_pkg::t_result want;
        tga_pkg::t_result res;
        if (!i_rst_n) begin
            clear_state();
            decoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_pixel_valid, i_red, i_green, i_blue, i_alpha, i_has_alpha,
                       i_repeat_count, i_image_width, i_image_height, i_status,
                       i_image_end};
                if (decoded_q.size() == 0) begin
                    $error("result arrived with nothing outstanding");
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("pixel_valid", int'(want.pixel_valid),
                                int'(got.pixel_valid));
                    check_field("red", int'(want.red), int'(got.red));
                    check_field("green", int'(want.green), int'(got.green));
                    check_field("blue", int'(want.blue), int'(got.blue));
                    check_field("alpha", int'(want.alpha), int'(got.alpha));
                    check_field("has_alpha", int'(want.has_alpha), int'(got.has_alpha));
                    check_field("repeat_count", int'(want.repeat_count),
                                int'(got.repeat_count));
                    check_field("image_width", int'(want.image_width),
                                int'(got.image_width));
                    check_field("image_height", int'(want.image_height),
                                int'(got.image_height));
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("image_end", int'(want.image_end), int'(got.image_end));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_byte(i_data_byte, i_last_byte, res)) decoded_q.push_back(res);
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

[sim/tga_image_decoder_tb.sv]
module tga_image_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1600;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int SETTLE      = 16;    // decode stage plus two-entry buffer, with margin

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_pixel_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_has_alpha;
    logic [7:0]  o_repeat_count;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic [2:0]  o_status;
    logic        o_image_end;

    int          fail_count;
    int          results_due;
    int          cycle_count = 0;

    // stimulus shaping, shared by sender and receiver
    bit          quiet    = 1'b0;   // no idling on either side
    bit          hold_req = 1'b0;   // asks the receiver for a long hold-off
    int          hold_left = 0;

    logic [7:0]  file_q[$];         // bytes of the file being built

    tga_image_decoder uut (.*);

    tga_image_decoder_checker decode_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_pixel_valid  (o_pixel_valid),
        .i_red          (o_red),
        .i_green        (o_green),
        .i_blue         (o_blue),
        .i_alpha        (o_alpha),
        .i_has_alpha    (o_has_alpha),
        .i_repeat_count (o_repeat_count),
        .i_image_width  (o_image_width),
        .i_image_height (o_image_height),
        .i_status       (o_status),
        .i_image_end    (o_image_end),
        .o_errors       (fail_count),
        .o_pending      (results_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // safety net: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver. Stalls now and then at random; on request holds the output
    // off for a long stretch so the output buffer fills and the input stalls.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    // Offer one byte, idling first at random. Called at a rising edge and
    // returns at the edge where the item is taken. The stall is read at the
    // falling edge, where it holds the value seen by the next rising edge.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 10) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // the final byte of every file carries the last-byte flag
    task automatic send_file();
        for (int k = 0; k < file_q.size(); k++) send_byte(file_q[k], k == file_q.size() - 1);
        file_q.delete();
    endtask

    // sender stops and waits until every outstanding result is out
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    // type header: all zero bar the image-type code
    task automatic add_header(input logic [7:0] code);
        for (int k = 0; k <= int'(tga_pkg::TYPE_LAST); k++)
            file_q.push_back((k == int'(tga_pkg::TYPE_CODE_POS)) ? code : 8'd0);
    endtask

    // width, height, bits per pixel, then a descriptor the block ignores
    task automatic add_info(input logic [15:0] w, input logic [15:0] h, input logic [7:0] bpp);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(bpp);
        file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_pixel(input bit with_alpha);
        for (int k = 0; k < (with_alpha ? 4 : 3); k++) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // random filler; after an end the block swallows it up to the last byte
    task automatic add_junk(input int count);
        for (int k = 0; k < count; k++) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int         file_no;
        int         pick;
        int         w;
        int         h;
        int         n;
        int         left;
        int         cut;
        int         pos;
        int         items_sent;
        bit         rle;
        bit         with_alpha;
        bit         overrun_ok;
        bit         run;
        logic [7:0] bpp;

        file_no    = 0;
        items_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed files ----
        // raw 1x1, 24 bpp, colour bytes 00, FF and 5A, last flag on the only pixel
        add_header(tga_pkg::TYPE_RAW);
        add_info(16'd1, 16'd1, tga_pkg::BPP_RGB);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h5A);
        send_file();
        // RLE 3x1 RGBA: single-pixel run, then a two-pixel raw packet, then junk
        add_header(tga_pkg::TYPE_RLE);
        add_info(16'd3, 16'd1, tga_pkg::BPP_RGBA);
        file_q.push_back(tga_pkg::RUN_BIAS + 8'd1);
        add_junk(0);
        repeat (4) file_q.push_back(8'hFF);
        file_q.push_back(8'd1);
        add_pixel(1'b1);
        add_pixel(1'b1);
        add_junk(2);
        send_file();
        // bad image type, file ends on that same byte: bad type wins over truncation
        add_header(tga_pkg::TYPE_RAW);
        file_q[tga_pkg::TYPE_CODE_POS] = 8'd3;
        send_file();
        // zero width
        add_header(tga_pkg::TYPE_RLE);
        add_info(16'd0, 16'd1, tga_pkg::BPP_RGB);
        add_junk(3);
        send_file();
        // unsupported depth, file ends on the descriptor
        add_header(tga_pkg::TYPE_RAW);
        add_info(16'd1, 16'd1, 8'd16);
        send_file();
        // zero height
        add_header(tga_pkg::TYPE_RAW);
        add_info(16'd2, 16'd0, tga_pkg::BPP_RGBA);
        add_junk(1);
        send_file();
        // longest run into a two-pixel image: clipped, overrun flagged
        add_header(tga_pkg::TYPE_RLE);
        add_info(16'd1, 16'd2, tga_pkg::BPP_RGB);
        file_q.push_back(8'hFF);
        add_pixel(1'b0);
        add_junk(2);
        send_file();
        // longest raw packet into a one-pixel image: the rest is dropped
        add_header(tga_pkg::TYPE_RLE);
        add_info(16'd1, 16'd1, tga_pkg::BPP_RGB);
        file_q.push_back(tga_pkg::RAW_LIMIT - 8'd1);
        add_pixel(1'b0);
        add_pixel(1'b0);
        send_file();
        // largest image, cut short on the byte that finishes a full run
        add_header(tga_pkg::TYPE_RLE);
        add_info(16'hFFFF, 16'hFFFF, tga_pkg::BPP_RGBA);
        file_q.push_back(8'hFF);
        add_pixel(1'b1);
        send_file();
        // a file of one byte
        file_q.push_back(8'h00);
        send_file();
        // truncated part way through a pixel
        add_header(tga_pkg::TYPE_RAW);
        add_info(16'd2, 16'd1, tga_pkg::BPP_RGB);
        add_pixel(1'b0);
        file_q.push_back(8'h11);
        send_file();

        // ---- random files ----
        while (items_sent < ITEM_TARGET) begin
            file_no++;
            if (file_no == 6) hold_req = 1'b1;
            if (file_no == 14) wait_results_done();
            quiet = (file_no >= 20 && file_no < 28);

            pick       = $urandom_range(0, 99);
            rle        = 1'($urandom_range(0, 1));
            with_alpha = 1'($urandom_range(0, 1));
            overrun_ok = ($urandom_range(0, 99) < 15);
            if (rle && $urandom_range(0, 9) == 0) begin
                w = $urandom_range(200, 600);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 5);
                h = $urandom_range(1, 4);
            end
            bpp = with_alpha ? tga_pkg::BPP_RGBA : tga_pkg::BPP_RGB;

            if (pick < 10) begin
                // type header with one byte disturbed
                add_header(rle ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW);
                pos = $urandom_range(0, int'(tga_pkg::TYPE_LAST));
                file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
                items_sent += file_q.size();
                add_junk($urandom_range(0, 20));
            end else if (pick < 20) begin
                // info block with a zero size or an unsupported depth
                add_header(rle ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW);
                case ($urandom_range(0, 2))
                    0: add_info(16'd0, 16'(h), bpp);
                    1: add_info(16'(w), 16'd0, bpp);
                    default: begin
                        do bpp = 8'($urandom_range(0, 255));
                        while (bpp == tga_pkg::BPP_RGB || bpp == tga_pkg::BPP_RGBA);
                        add_info(16'(w), 16'(h), bpp);
                    end
                endcase
                items_sent += file_q.size();
                add_junk($urandom_range(0, 4));
            end else if (pick < 25) begin
                // plain noise
                add_junk($urandom_range(1, 30));
                items_sent += file_q.size();
            end else begin
                // well-formed image with random content
                add_header(rle ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW);
                add_info(16'(w), 16'(h), bpp);
                left = w * h;
                if (!rle) begin
                    for (int p = 0; p < left; p++) add_pixel(with_alpha);
                end else begin
                    while (left > 0) begin
                        run = 1'($urandom_range(0, 1));
                        if (run)
                            n = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                                     : $urandom_range(1, 128);
                        else
                            n = overrun_ok ? $urandom_range(1, 128) : $urandom_range(1, 6);
                        if (!overrun_ok && n > left) n = left;
                        if (run) begin
                            file_q.push_back(tga_pkg::RUN_BIAS + 8'(n));
                            add_pixel(with_alpha);
                        end else begin
                            file_q.push_back(8'(n - 1));
                            for (int p = 0; p < n && p < left; p++) add_pixel(with_alpha);
                        end
                        left -= (n < left) ? n : left;
                    end
                end
                if (pick < 40) begin
                    // cut short anywhere before the final byte
                    cut = $urandom_range(0, file_q.size() - 2);
                    while (file_q.size() > cut + 1) void'(file_q.pop_back());
                    items_sent += file_q.size();
                end else begin
                    items_sent += file_q.size();
                    if ($urandom_range(0, 1)) add_junk($urandom_range(1, 4));
                end
            end
            send_file();
        end

        wait_results_done();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
